// ===== rtl/sm3_block_compression_assert.svh =====
`ifndef SM3_BLOCK_COMPRESSION_ASSERT_SVH
`define SM3_BLOCK_COMPRESSION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SM3BC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SM3BC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sm3bc_pkg.sv =====
package sm3bc_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
        t_word f;
        t_word g;
        t_word h;
    } t_work;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } t_state_e;

    localparam t_word SM3_IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    // round constant for rounds 0..15
    localparam t_word TJ_LO = 32'h79cc4519;
    // 0x7a879d8a already rotated by 16 for round 16
    localparam t_word TJ_HI_ROT = 32'h9d8a7a87;

    localparam logic [3:0] LAST_WORD     = 4'd15;
    localparam logic [5:0] LAST_LO_ROUND = 6'd15;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_IDX      = 3'd7;

    function automatic t_word rol32(t_word x, int unsigned n);
        t_word res;
        res = (x << n) | (x >> (32 - n));
        return res;
    endfunction

    function automatic t_word perm0(t_word x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic t_word perm1(t_word x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

endpackage

// ===== rtl/sm3_block_compression.sv =====
// SM3 compression of one padded 512-bit block. Message words arrive one per slave transaction
// (tuser high on the first word of a message reloads the standard IV and restarts the block).
// After the sixteenth word the slave side drops tready while one shared round unit runs one
// round per cycle for all 64 rounds, with the message schedule expanded on the fly in a 16-word
// shift window. The updated chaining value then leaves as eight master transactions, A first,
// tuser carrying the word index and tlast marking H; the slave side reopens after the last one.
module sm3_block_compression
    import sm3bc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] message_word
    input  logic        i_s_tuser,   // [0] new_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_tuser,   // [2:0] word_index
    output logic        o_m_tlast
);

    t_state_e   r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [5:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    t_word      r_cv [8];
    t_word      n_cv [8];
    t_work      r_work, n_work;
    t_word      r_tj, n_tj;

    logic  s_acc;
    logic  m_acc;
    logic  in_round;
    t_word w_j;
    t_word w_j4;
    t_work round_out;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign m_acc    = o_m_tvalid && i_m_tready;
    assign in_round = (r_state == ST_ROUND);

    sm3bc_msg_sched u_sched (
        .i_clk       (i_clk),
        .i_load      (s_acc),
        .i_load_word (i_s_tdata),
        .i_step      (in_round),
        .o_w_j       (w_j),
        .o_w_j4      (w_j4)
    );

    sm3bc_round u_round (
        .i_work (r_work),
        .i_w_j  (w_j),
        .i_w_j4 (w_j4),
        .i_tj   (r_tj),
        .i_low  (r_round[5:4] == 2'b00),
        .o_work (round_out)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (s_acc && !i_s_tuser && (r_cnt == LAST_WORD)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_acc && (r_idx == LAST_IDX)) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            ST_LOAD:  o_s_tready = 1'b1;
            ST_ROUND: o_s_tready = 1'b0;
            ST_OUT:   o_m_tvalid = 1'b1;
            default:  o_s_tready = 1'b0;
        endcase
    end

    assign o_m_tdata = r_cv[r_idx];
    assign o_m_tuser = r_idx;
    assign o_m_tlast = (r_idx == LAST_IDX);

    always_comb begin
        n_cnt   = r_cnt;
        n_round = r_round;
        n_idx   = r_idx;
        n_cv    = r_cv;
        n_work  = r_work;
        n_tj    = r_tj;
        unique case (r_state)
            ST_LOAD: begin
                if (s_acc) begin
                    if (i_s_tuser) begin
                        n_cv  = SM3_IV;
                        n_cnt = 4'd1;
                    end else if (r_cnt == LAST_WORD) begin
                        n_cnt   = '0;
                        n_round = '0;
                        n_tj    = TJ_LO;
                        n_work  = '{a: r_cv[0], b: r_cv[1], c: r_cv[2], d: r_cv[3],
                                    e: r_cv[4], f: r_cv[5], g: r_cv[6], h: r_cv[7]};
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            ST_ROUND: begin
                n_work  = round_out;
                n_round = r_round + 6'd1;
                n_tj    = (r_round == LAST_LO_ROUND) ? TJ_HI_ROT : rol32(r_tj, 1);
                if (r_round == LAST_ROUND) begin
                    n_cv[0] = r_cv[0] ^ round_out.a;
                    n_cv[1] = r_cv[1] ^ round_out.b;
                    n_cv[2] = r_cv[2] ^ round_out.c;
                    n_cv[3] = r_cv[3] ^ round_out.d;
                    n_cv[4] = r_cv[4] ^ round_out.e;
                    n_cv[5] = r_cv[5] ^ round_out.f;
                    n_cv[6] = r_cv[6] ^ round_out.g;
                    n_cv[7] = r_cv[7] ^ round_out.h;
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    n_idx = r_idx + 3'd1;
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_cv    <= SM3_IV;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_cv    <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_tj   <= n_tj;
    end

endmodule

// ===== rtl/sm3bc_msg_sched.sv =====
module sm3bc_msg_sched
    import sm3bc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,
    input  t_word i_load_word,
    input  logic  i_step,
    output t_word o_w_j,
    output t_word o_w_j4
);

    t_word r_w [16];
    t_word expand;

    // w[j+16] from the sliding 16-word window
    always_comb begin
        expand = perm1(r_w[0] ^ r_w[7] ^ rol32(r_w[13], 15))
                 ^ rol32(r_w[3], 7) ^ r_w[10];
    end

    always_ff @(posedge i_clk) begin
        if (i_load || i_step) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[15] <= i_load ? i_load_word : expand;
        end
    end

    assign o_w_j  = r_w[0];
    assign o_w_j4 = r_w[4];

endmodule

// ===== rtl/sm3bc_round.sv =====
module sm3bc_round
    import sm3bc_pkg::*;
(
    input  t_work i_work,
    input  t_word i_w_j,
    input  t_word i_w_j4,
    input  t_word i_tj,
    input  logic  i_low,
    output t_work o_work
);

    t_word a12;
    t_word ss1;
    t_word ss2;
    t_word ff;
    t_word gg;
    t_word tt1;
    t_word tt2;

    always_comb begin
        a12 = rol32(i_work.a, 12);
        ss1 = rol32(a12 + i_work.e + i_tj, 7);
        ss2 = ss1 ^ a12;
        if (i_low) begin
            ff = i_work.a ^ i_work.b ^ i_work.c;
            gg = i_work.e ^ i_work.f ^ i_work.g;
        end else begin
            ff = (i_work.a & i_work.b) | (i_work.a & i_work.c) | (i_work.b & i_work.c);
            gg = (i_work.e & i_work.f) | (~i_work.e & i_work.g);
        end
        tt1 = ff + i_work.d + ss2 + (i_w_j ^ i_w_j4);
        tt2 = gg + i_work.h + ss1 + i_w_j;

        o_work.a = tt1;
        o_work.b = i_work.a;
        o_work.c = rol32(i_work.b, 9);
        o_work.d = i_work.c;
        o_work.e = perm0(tt2);
        o_work.f = i_work.e;
        o_work.g = rol32(i_work.f, 19);
        o_work.h = i_work.g;
    end

endmodule

// ===== rtl/sm3bc_checker.sv =====
`include "sm3_block_compression_assert.svh"

module sm3bc_checker
    import sm3bc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    logic        m_acc;
    logic        m_stall;
    logic [34:0] m_beat;
    logic        idx_is_last;
    logic [2:0]  r_idx_next;
    logic        idx_ok;

    assign m_acc       = o_m_tvalid && i_m_tready;
    assign m_stall     = o_m_tvalid && !i_m_tready;
    assign m_beat      = {o_m_tdata, o_m_tuser};
    assign idx_is_last = (o_m_tuser == LAST_IDX);
    assign idx_ok      = (o_m_tuser == r_idx_next);

    always_ff @(posedge i_clk) begin
        r_idx_next <= o_m_tuser + 3'd1;
    end

    // no input taken while digest words are pending
    `SM3BC_ASSERT_NOW(a_no_overlap, o_m_tvalid, !o_s_tready, "input ready during output")

    // stalled digest transaction holds
    `SM3BC_ASSERT_NXT(a_hold, m_stall, o_m_tvalid && $stable(m_beat), "stalled output moved")

    // tlast only on word H
    `SM3BC_ASSERT_NOW(a_last_idx, o_m_tvalid, o_m_tlast == idx_is_last, "tlast misplaced")

    // words come out in order, then input reopens
    `SM3BC_ASSERT_NXT(a_idx_seq, m_acc && !o_m_tlast, o_m_tvalid && idx_ok, "index skipped")

    `SM3BC_ASSERT_NXT(a_reopen, m_acc && o_m_tlast, o_s_tready && !o_m_tvalid, "no reopen")

endmodule

bind sm3_block_compression sm3bc_checker u_checker (.*);

// ===== test/tb_sm3_block_compression.sv =====
module tb_sm3_block_compression;
    timeunit 1ns;
    timeprecision 1ps;

    import sm3bc_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned TOTAL_ITEMS = 230;
    localparam int unsigned MAX_REPORTS = 10;

    localparam t_word CORNER_WORDS [16] = '{
        32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
        32'h7fffffff, 32'hfffffffe, 32'haaaaaaaa, 32'h55555555,
        32'h61626380, 32'h00000000, 32'hffffffff, 32'h00000000,
        32'hffffffff, 32'h0000ffff, 32'hffff0000, 32'h00000018
    };

    typedef struct packed {
        t_word      word;
        logic [2:0] idx;
        logic       last;
    } t_digest;

    class t_digest_tracker;
        t_word       chain [8];
        t_word       msg [16];
        int unsigned fill;
        int unsigned mismatches;
        t_digest     digest_q [$];

        function new();
            reload_iv();
            mismatches = 0;
        endfunction

        function void reload_iv();
            chain = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
            fill = 0;
        endfunction

        function t_word rotl(t_word x, int unsigned n);
            logic [63:0] dbl;
            dbl = {x, x} << (n % 32);
            return dbl[63:32];
        endfunction

        function t_word mix_p0(t_word x);
            return x ^ rotl(x, 9) ^ rotl(x, 17);
        endfunction

        function t_word mix_p1(t_word x);
            return x ^ rotl(x, 15) ^ rotl(x, 23);
        endfunction

        function void compress();
            t_word w [68];
            t_word a, b, c, d, e, f, g, h;
            t_word tj, a12, ss1, ss2, ff, gg, tt1, tt2;
            for (int j = 0; j < 16; j++)
                w[j] = msg[j];
            for (int j = 16; j < 68; j++)
                w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15))
                       ^ rotl(w[j-13], 7) ^ w[j-6];
            {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                        chain[4], chain[5], chain[6], chain[7]};
            for (int j = 0; j < 64; j++) begin
                tj  = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
                a12 = rotl(a, 12);
                ss1 = rotl(a12 + e + rotl(tj, j), 7);
                ss2 = ss1 ^ a12;
                if (j < 16) begin
                    ff = a ^ b ^ c;
                    gg = e ^ f ^ g;
                end else begin
                    ff = (a & b) | (a & c) | (b & c);
                    gg = (e & f) | (~e & g);
                end
                tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
                tt2 = gg + h + ss1 + w[j];
                d = c;
                c = rotl(b, 9);
                b = a;
                a = tt1;
                h = g;
                g = rotl(f, 19);
                f = e;
                e = mix_p0(tt2);
            end
            chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
            chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
        endfunction

        function void take_word(t_word word, logic fresh);
            t_digest item;
            if (fresh)
                reload_iv();
            msg[fill] = word;
            fill++;
            if (fill == 16) begin
                fill = 0;
                compress();
                for (int k = 0; k < 8; k++) begin
                    item.word = chain[k];
                    item.idx  = 3'(k);
                    item.last = (k == 7);
                    digest_q.push_back(item);
                end
            end
        endfunction

        function void check_digest(t_word word, logic [2:0] idx, logic last);
            t_digest want;
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected digest transaction: word %h idx %0d last %b",
                             word, idx, last);
                return;
            end
            want = digest_q.pop_front();
            if (want.word !== word || want.idx !== idx || want.last !== last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                             want.word, want.idx, want.last, word, idx, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // [31:0] message_word
    logic        i_s_tuser = 1'b0; // [0] new_message
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // [31:0] digest_word
    logic [2:0]  o_m_tuser;        // [2:0] word_index
    logic        o_m_tlast;

    t_digest_tracker board = new();
    bit              steady = 1'b0;
    int unsigned     out_hold = 0;
    int unsigned     quiet_cycles = 0;

    sm3_block_compression dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_word rand_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h00000000;
        if (r == 1)
            return 32'hffffffff;
        if (r == 2)
            return t_word'(1) << $urandom_range(0, 31);
        return $urandom;
    endfunction

    task automatic send_word(input t_word word, input logic fresh);
        int unsigned gap;
        gap = idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= fresh;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        board.take_word(word, fresh);
    endtask

    task automatic wait_for_digests();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (board.digest_q.size() != 0);
    endtask

    // digest side: check, then pick the next tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                board.check_digest(o_m_tdata, o_m_tuser, o_m_tlast);
            if (out_hold != 0) begin
                out_hold = out_hold - 1;
                i_m_tready <= 1'b0;
            end else begin
                out_hold = idle_len();
                i_m_tready <= (out_hold == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned sent;
        int unsigned kind;
        int unsigned n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first block straight after reset, no new-message flag
        for (int k = 0; k < 16; k++)
            send_word(CORNER_WORDS[k], 1'b0);
        wait_for_digests();

        // partial message, dropped by the restart that opens the random part
        send_word(32'hffffffff, 1'b1);
        send_word(32'h00000000, 1'b0);
        send_word(32'h80000000, 1'b0);
        send_word(32'h00000001, 1'b0);

        sent = 20;
        kind = 2;
        while (sent < TOTAL_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            if (kind == 0) begin
                n = $urandom_range(1, 15);
                for (int k = 0; k < n; k++)
                    send_word(rand_word(), (k == 0) ? 1'($urandom_range(0, 1))
                                                    : ($urandom_range(0, 15) == 0));
            end else begin
                n = ($urandom_range(0, 3) == 0) ? 16 * $urandom_range(2, 3) : 16;
                // kind 1 continues from the current chaining value
                for (int k = 0; k < n; k++)
                    send_word(rand_word(), (k == 0) && (kind != 1));
            end
            sent += n;
            kind = $urandom_range(0, 9);
        end
        steady = 1'b0;

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.digest_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
